[src/lmbcm_pkg.sv]
// ----------------------------------------------------------------------------
// lmbcm_pkg
// Shared types and constants for the LED matrix BCM scan driver.
// ----------------------------------------------------------------------------
package lmbcm_pkg;

    // Default geometry
    localparam int COLUMNS_DEF    = 32;
    localparam int HALF_ROWS_DEF  = 8;
    localparam int BIT_PLANES_DEF = 4;

    // Payload widths
    localparam int OP_W       = 2;
    localparam int PIX_X_W    = 5;
    localparam int PIX_Y_W    = 4;
    localparam int COLOR_W    = 16;
    localparam int BASE_W     = 16;
    localparam int HOLD_W     = 19;
    localparam int ROW_ADDR_W = 3;
    localparam int COL_OUT_W  = 5;

    localparam logic [BASE_W-1:0] BASE_RESET = 16'd100;

    // Lowest color bit used by plane 0, per channel
    localparam logic [3:0] BLUE_LSB  = 4'd1;
    localparam logic [3:0] GREEN_LSB = 4'd7;
    localparam logic [3:0] RED_LSB   = 4'd12;

    typedef enum logic [OP_W-1:0] {
        OP_REFRESH = 2'd0,
        OP_WRITE   = 2'd1,
        OP_SWAP    = 2'd2
    } t_op;

    typedef enum logic [2:0] {
        ST_CLR_ALL,
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_CLR_BUF
    } t_state;

endpackage

[src/led_matrix_bcm_scan_driver_top.sv]
// ----------------------------------------------------------------------------
// led_matrix_bcm_scan_driver_top
// Double-buffered RGB565 panel scanner with binary code modulation planes.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: a transaction is taken at a clock edge with i_start high
//   and o_busy low. A pixel write or a swap request gives no result; the
//   next command can follow right away.
//   A refresh step reads one column per cycle from the front buffer (one
//   read port on each half-panel RAM) and emits COLUMNS beats on the result
//   ports, one per cycle, each marked by o_strobe for one cycle. The first
//   beat follows the accepting edge through the scan state, the RAM read
//   register and the output registers; o_busy stays high through scan and drain.
//   o_last marks the final beat; o_frame_swapped on it says the buffers
//   were exchanged at the end of this step. A swap adds a clearing pass
//   over the old front buffer, while busy is high.
//   Reset (synchronous, active low) starts a clearing pass over both
//   buffers while busy is high.
//   The receiver cannot stall: results are taken in the cycle shown.
//   Config: i_cfg_data is written on i_cfg_valid; o_cfg_ready is always
//   high. Write it only while the block is idle.
// ----------------------------------------------------------------------------
module led_matrix_bcm_scan_driver_top
    import lmbcm_pkg::*;
#(
    parameter int COLUMNS    = COLUMNS_DEF,
    parameter int HALF_ROWS  = HALF_ROWS_DEF,
    parameter int BIT_PLANES = BIT_PLANES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // command channel
    input  logic                  i_start,
    output logic                  o_busy,
    input  logic [OP_W-1:0]       i_operation,
    input  logic [PIX_X_W-1:0]    i_pixel_x,
    input  logic [PIX_Y_W-1:0]    i_pixel_y,
    input  logic [COLOR_W-1:0]    i_pixel_color,
    // config channel
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [BASE_W-1:0]     i_cfg_data,
    // result channel
    output logic                  o_strobe,
    output logic [ROW_ADDR_W-1:0] o_row_address,
    output logic [COL_OUT_W-1:0]  o_column,
    output logic                  o_upper_red,
    output logic                  o_upper_green,
    output logic                  o_upper_blue,
    output logic                  o_lower_red,
    output logic                  o_lower_green,
    output logic                  o_lower_blue,
    output logic [HOLD_W-1:0]     o_hold_time,
    output logic                  o_frame_swapped,
    output logic                  o_last
);

    localparam int CW    = $clog2(COLUMNS);
    localparam int RW    = $clog2(HALF_ROWS);
    localparam int PW    = (BIT_PLANES > 1) ? $clog2(BIT_PLANES) : 1;
    localparam int AW    = 1 + RW + CW;     // buffer select, row, column
    localparam int DEPTH = 2 ** AW;

    // ------------------------------------------------------------------
    // State
    // ------------------------------------------------------------------
    t_state              r_state, n_state;
    logic [CW-1:0]       r_col;             // column being read
    logic [AW-1:0]       r_clr;             // clearing sweep pointer
    logic [PW-1:0]       r_plane;
    logic [RW-1:0]       r_row;
    logic                r_front_sel;       // 1: buffer 0 is front
    logic                r_pending;         // swap requested
    logic [BASE_W-1:0]   r_base;
    logic [HOLD_W-1:0]   r_hold;            // hold time for the current step
    logic                r_swap_now;        // this step ends the frame with a swap
    logic                r_beat_vld;        // RAM data valid this cycle
    logic [CW-1:0]       r_beat_col;

    // ------------------------------------------------------------------
    // Command decode
    // ------------------------------------------------------------------
    logic                accept;
    t_op                 op;
    logic [7:0]          x_ext;
    logic [6:0]          y_ext;
    logic [6:0]          y_half;
    logic                y_lower;
    logic                pix_ok;

    assign accept  = i_start && !o_busy;
    assign op      = t_op'(i_operation);
    assign x_ext   = 8'(i_pixel_x);
    assign y_ext   = 7'(i_pixel_y);
    assign y_lower = (y_ext >= 7'(HALF_ROWS));
    assign y_half  = y_lower ? (y_ext - 7'(HALF_ROWS)) : y_ext;
    assign pix_ok  = (x_ext < 8'(COLUMNS)) && (y_ext < 7'(2 * HALF_ROWS));

    assign o_busy      = (r_state != ST_IDLE);
    assign o_cfg_ready = 1'b1;

    // ------------------------------------------------------------------
    // Half-panel memories: upper rows and lower rows, read together
    // ------------------------------------------------------------------
    logic                we_up, we_lo;
    logic [AW-1:0]       waddr, raddr;
    logic [COLOR_W-1:0]  wdata;
    logic [COLOR_W-1:0]  rd_up, rd_lo;

    lmbcm_ram #(.WIDTH(COLOR_W), .DEPTH(DEPTH)) u_ram_upper (
        .i_clk   (i_clk),
        .i_we    (we_up),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rd_up)
    );

    lmbcm_ram #(.WIDTH(COLOR_W), .DEPTH(DEPTH)) u_ram_lower (
        .i_clk   (i_clk),
        .i_we    (we_lo),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rd_lo)
    );

    // ------------------------------------------------------------------
    // Sequencer: next state
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLR_ALL: begin
                if (r_clr == {AW{1'b1}}) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (accept && op == OP_REFRESH) n_state = ST_SCAN;
            end
            ST_SCAN: begin
                if (r_col == CW'(COLUMNS - 1)) n_state = ST_DRAIN;
            end
            ST_DRAIN: begin
                n_state = r_swap_now ? ST_CLR_BUF : ST_IDLE;
            end
            ST_CLR_BUF: begin
                if (r_clr[AW-2:0] == {(AW-1){1'b1}}) n_state = ST_IDLE;
            end
            default: n_state = ST_CLR_ALL;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer: memory controls
    // ------------------------------------------------------------------
    always_comb begin
        we_up = 1'b0;
        we_lo = 1'b0;
        waddr = {r_front_sel, RW'(y_half), CW'(x_ext)};  // back buffer
        wdata = i_pixel_color;
        raddr = {~r_front_sel, r_row, r_col};            // front buffer
        unique case (r_state)
            ST_CLR_ALL: begin
                we_up = 1'b1;
                we_lo = 1'b1;
                waddr = r_clr;
                wdata = '0;
            end
            ST_CLR_BUF: begin
                // old front is the new back buffer
                we_up = 1'b1;
                we_lo = 1'b1;
                waddr = {r_front_sel, r_clr[AW-2:0]};
                wdata = '0;
            end
            ST_IDLE: begin
                if (accept && op == OP_WRITE && pix_ok) begin
                    we_up = !y_lower;
                    we_lo = y_lower;
                end
            end
            ST_SCAN, ST_DRAIN: begin
            end
            default: begin
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    logic                last_plane, last_row;
    logic [3:0]          plane4;
    logic                beat_last;
    logic [7:0]          row8, col8;

    assign last_plane = (r_plane == PW'(BIT_PLANES - 1));
    assign last_row   = (r_row == RW'(HALF_ROWS - 1));
    assign plane4     = 4'(r_plane);
    assign beat_last  = (r_beat_col == CW'(COLUMNS - 1));
    assign row8       = 8'(r_row);
    assign col8       = 8'(r_beat_col);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLR_ALL;
            r_col       <= '0;
            r_clr       <= '0;
            r_plane     <= '0;
            r_row       <= '0;
            r_front_sel <= 1'b1;
            r_pending   <= 1'b0;
            r_base      <= BASE_RESET;
            r_beat_vld  <= 1'b0;
            o_strobe    <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_valid && o_cfg_ready) r_base <= i_cfg_data;

            if (r_state == ST_CLR_ALL || r_state == ST_CLR_BUF) begin
                r_clr <= r_clr + AW'(1);
            end else begin
                r_clr <= '0;
            end

            if (r_state == ST_SCAN) begin
                r_col <= (r_col == CW'(COLUMNS - 1)) ? '0 : r_col + CW'(1);
            end

            if (accept && op == OP_SWAP) r_pending <= 1'b1;

            // Advance plane, row and buffers once the last read has returned
            if (r_state == ST_DRAIN) begin
                if (last_plane) begin
                    r_plane <= '0;
                    if (last_row) begin
                        r_row <= '0;
                        if (r_pending) begin
                            r_front_sel <= ~r_front_sel;
                            r_pending   <= 1'b0;
                        end
                    end else begin
                        r_row <= r_row + RW'(1);
                    end
                end else begin
                    r_plane <= r_plane + PW'(1);
                end
            end

            r_beat_vld <= (r_state == ST_SCAN);
            o_strobe   <= r_beat_vld;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (accept && op == OP_REFRESH) begin
            r_hold     <= HOLD_W'(r_base) << r_plane;
            r_swap_now <= last_plane && last_row && r_pending;
        end
        r_beat_col <= r_col;
        if (r_beat_vld) begin
            o_row_address   <= row8[ROW_ADDR_W-1:0];
            o_column        <= col8[COL_OUT_W-1:0];
            o_upper_red     <= rd_up[plane4 + RED_LSB];
            o_upper_green   <= rd_up[plane4 + GREEN_LSB];
            o_upper_blue    <= rd_up[plane4 + BLUE_LSB];
            o_lower_red     <= rd_lo[plane4 + RED_LSB];
            o_lower_green   <= rd_lo[plane4 + GREEN_LSB];
            o_lower_blue    <= rd_lo[plane4 + BLUE_LSB];
            o_hold_time     <= r_hold;
            o_last          <= beat_last;
            o_frame_swapped <= beat_last && r_swap_now;
        end
    end

endmodule

[src/lmbcm_ram.sv]
// ----------------------------------------------------------------------------
// lmbcm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lmbcm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 512,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

[bench/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the LED matrix BCM scan driver: a short table of
// directed commands, then random command traffic in several idling phases
// and base period settings. Every column beat is compared with a local
// model of both frame buffers, the plane and row counters, and the pending
// swap.
// ----------------------------------------------------------------------------
module tb_top;
    import lmbcm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          NUM_COLS      = COLUMNS_DEF;
    localparam int          NUM_PAIRS     = HALF_ROWS_DEF;
    localparam int          NUM_PLANES    = BIT_PLANES_DEF;
    localparam int          PHASE_CMDS    = 60;       // counted commands per phase
    localparam int          SETTLE_CYCLES = 300;      // covers a buffer clear pass
    localparam int unsigned CYCLE_LIMIT   = 400000;
    // Opcode 3 is not in t_op; the block must take it and do nothing.
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    // One column beat as seen on the result ports.
    // rgb packs {upper r,g,b, lower r,g,b}.
    typedef struct packed {
        logic [ROW_ADDR_W-1:0] row_addr;
        logic [COL_OUT_W-1:0]  col;
        logic [5:0]            rgb;
        logic [HOLD_W-1:0]     hold;
        logic                  swapped;
        logic                  last;
    } t_beat;

    // Directed command; typed rows carry the beats written out by hand.
    typedef struct packed {
        logic [OP_W-1:0]       op;
        logic [PIX_X_W-1:0]    x;
        logic [PIX_Y_W-1:0]    y;
        logic [COLOR_W-1:0]    color;
        logic                  typed;
        logic [ROW_ADDR_W-1:0] t_row;
        logic [HOLD_W-1:0]     t_hold;
        logic [5:0]            t_rgb;
    } t_cmd_row;

    // ------------------------------------------------------------------------
    // DUT hookup
    // ------------------------------------------------------------------------
    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_start;
    logic                  o_busy;
    logic [OP_W-1:0]       i_operation;
    logic [PIX_X_W-1:0]    i_pixel_x;
    logic [PIX_Y_W-1:0]    i_pixel_y;
    logic [COLOR_W-1:0]    i_pixel_color;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [BASE_W-1:0]     i_cfg_data;
    logic                  o_strobe;
    logic [ROW_ADDR_W-1:0] o_row_address;
    logic [COL_OUT_W-1:0]  o_column;
    logic                  o_upper_red;
    logic                  o_upper_green;
    logic                  o_upper_blue;
    logic                  o_lower_red;
    logic                  o_lower_green;
    logic                  o_lower_blue;
    logic [HOLD_W-1:0]     o_hold_time;
    logic                  o_frame_swapped;
    logic                  o_last;

    led_matrix_bcm_scan_driver_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (i_start),
        .o_busy          (o_busy),
        .i_operation     (i_operation),
        .i_pixel_x       (i_pixel_x),
        .i_pixel_y       (i_pixel_y),
        .i_pixel_color   (i_pixel_color),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .o_strobe        (o_strobe),
        .o_row_address   (o_row_address),
        .o_column        (o_column),
        .o_upper_red     (o_upper_red),
        .o_upper_green   (o_upper_green),
        .o_upper_blue    (o_upper_blue),
        .o_lower_red     (o_lower_red),
        .o_lower_green   (o_lower_green),
        .o_lower_blue    (o_lower_blue),
        .o_hold_time     (o_hold_time),
        .o_frame_swapped (o_frame_swapped),
        .o_last          (o_last)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Panel model: both frame buffers plus scan state
    // ------------------------------------------------------------------------
    logic [COLOR_W-1:0]    frame_mem [2][2*NUM_PAIRS][NUM_COLS];
    logic                  shown_buf;      // buffer on the panel, 0 after reset
    logic [1:0]            scan_plane;
    logic [ROW_ADDR_W-1:0] scan_row;
    logic                  swap_armed;
    logic [BASE_W-1:0]     base_us;

    t_beat       pending_beats[$];         // beats owed by the block, oldest first
    int unsigned err_count     = 0;
    int unsigned beats_checked = 0;
    int unsigned cmds_taken    = 0;
    int unsigned refresh_steps = 0;
    int unsigned swaps_seen    = 0;
    int unsigned cycle_count   = 0;

    task automatic reset_panel_model();
        foreach (frame_mem[b, r, c]) frame_mem[b][r][c] = '0;
        shown_buf  = 1'b0;
        scan_plane = '0;
        scan_row   = '0;
        swap_armed = 1'b0;
        base_us    = BASE_RESET;
    endtask

    // Apply one accepted command to the model. A refresh step produces a
    // full row of beats; push_beats=0 lets a typed table row supply its own.
    task automatic run_panel_cmd(input logic [OP_W-1:0] op, input logic [PIX_X_W-1:0] x,
                                 input logic [PIX_Y_W-1:0] y, input logic [COLOR_W-1:0] color,
                                 input bit push_beats);
        t_beat              row_beats [NUM_COLS];
        logic [COLOR_W-1:0] up;
        logic [COLOR_W-1:0] lo;
        logic               did_swap;
        if (op == OP_WRITE) begin
            // writes always land in the hidden buffer
            frame_mem[~shown_buf][y][x] = color;
        end else if (op == OP_SWAP) begin
            swap_armed = 1'b1;
        end else if (op == OP_REFRESH) begin
            refresh_steps++;
            for (int c = 0; c < NUM_COLS; c++) begin
                up = frame_mem[shown_buf][{1'b0, scan_row}][c];
                lo = frame_mem[shown_buf][{1'b1, scan_row}][c];
                row_beats[c].row_addr = scan_row;
                row_beats[c].col      = c[COL_OUT_W-1:0];
                row_beats[c].rgb      = {up[scan_plane + RED_LSB], up[scan_plane + GREEN_LSB],
                                         up[scan_plane + BLUE_LSB], lo[scan_plane + RED_LSB],
                                         lo[scan_plane + GREEN_LSB], lo[scan_plane + BLUE_LSB]};
                row_beats[c].hold     = {{(HOLD_W-BASE_W){1'b0}}, base_us} << scan_plane;
                row_beats[c].swapped  = 1'b0;
                row_beats[c].last     = (c == NUM_COLS - 1);
            end
            // plane, then row, then frame end with an optional buffer exchange
            did_swap = 1'b0;
            if (scan_plane == NUM_PLANES - 1) begin
                scan_plane = '0;
                if (scan_row == NUM_PAIRS - 1) begin
                    scan_row = '0;
                    if (swap_armed) begin
                        // old front buffer is wiped before it becomes the back
                        for (int r = 0; r < 2*NUM_PAIRS; r++)
                            for (int c = 0; c < NUM_COLS; c++)
                                frame_mem[shown_buf][r][c] = '0;
                        shown_buf  = ~shown_buf;
                        swap_armed = 1'b0;
                        did_swap   = 1'b1;
                    end
                end else begin
                    scan_row = scan_row + 1'b1;
                end
            end else begin
                scan_plane = scan_plane + 1'b1;
            end
            row_beats[NUM_COLS-1].swapped = did_swap;
            if (push_beats)
                foreach (row_beats[c]) pending_beats.push_back(row_beats[c]);
        end
        // opcode 3: nothing at all
    endtask

    // ------------------------------------------------------------------------
    // Result checker: every strobed beat must match the oldest expectation
    // ------------------------------------------------------------------------
    function automatic void check_field(string name, int unsigned exp_v, int unsigned act_v);
        if (exp_v !== act_v) begin
            err_count++;
            $display("%0t ns: mismatch %s expected 0x%0h actual 0x%0h",
                     $time, name, exp_v, act_v);
        end
    endfunction

    always @(posedge i_clk) begin : beat_checker
        t_beat e;
        if (i_rst_n && o_strobe) begin
            if (pending_beats.size() == 0) begin
                err_count++;
                $display("%0t ns: unexpected beat row %0d col %0d (nothing expected)",
                         $time, o_row_address, o_column);
            end else begin
                e = pending_beats.pop_front();
                beats_checked++;
                check_field("row_address",   32'(e.row_addr), 32'(o_row_address));
                check_field("column",        32'(e.col),      32'(o_column));
                check_field("upper_red",     32'(e.rgb[5]),   32'(o_upper_red));
                check_field("upper_green",   32'(e.rgb[4]),   32'(o_upper_green));
                check_field("upper_blue",    32'(e.rgb[3]),   32'(o_upper_blue));
                check_field("lower_red",     32'(e.rgb[2]),   32'(o_lower_red));
                check_field("lower_green",   32'(e.rgb[1]),   32'(o_lower_green));
                check_field("lower_blue",    32'(e.rgb[0]),   32'(o_lower_blue));
                check_field("hold_time",     32'(e.hold),     32'(o_hold_time));
                check_field("frame_swapped", 32'(e.swapped),  32'(o_frame_swapped));
                check_field("last",          32'(e.last),     32'(o_last));
                if (o_last && o_frame_swapped) swaps_seen++;
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d beats still owed",
                     cycle_count, pending_beats.size());
            $display("status: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Command driver. Called at a falling edge and returns at one; start is
    // left high so back-to-back transactions never drop it.
    // ------------------------------------------------------------------------
    task automatic send_cmd(input logic [OP_W-1:0] op, input logic [PIX_X_W-1:0] x,
                            input logic [PIX_Y_W-1:0] y, input logic [COLOR_W-1:0] color,
                            input int unsigned idle_pct, input t_cmd_row typed_row);
        // random sender gaps, payload scribbled while start is low
        while ($urandom_range(99) < idle_pct) begin
            i_start       = 1'b0;
            i_operation   = OP_W'($urandom_range(3));
            i_pixel_x     = PIX_X_W'($urandom_range(31));
            i_pixel_y     = PIX_Y_W'($urandom_range(15));
            i_pixel_color = COLOR_W'($urandom_range(16'hFFFF));
            @(negedge i_clk);
        end
        i_start       = 1'b1;
        i_operation   = op;
        i_pixel_x     = x;
        i_pixel_y     = y;
        i_pixel_color = color;
        // busy here is the value before the edge, i.e. what the block saw
        do @(posedge i_clk); while (o_busy !== 1'b0);
        cmds_taken++;
        run_panel_cmd(op, x, y, color, !typed_row.typed);
        if (typed_row.typed)
            for (int c = 0; c < NUM_COLS; c++)
                pending_beats.push_back(t_beat'{row_addr: typed_row.t_row,
                                                col: c[COL_OUT_W-1:0],
                                                rgb: typed_row.t_rgb, hold: typed_row.t_hold,
                                                swapped: 1'b0, last: (c == NUM_COLS - 1)});
        @(negedge i_clk);
    endtask

    // Hold off until every owed beat is out.
    task automatic drain_beats();
        i_start = 1'b0;
        while (pending_beats.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Register write, only once the block is fully quiet: beats drained,
    // time for a possible buffer clear, and busy low.
    task automatic program_base(input logic [BASE_W-1:0] val);
        drain_beats();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        while (o_busy !== 1'b0) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_data  = val;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        base_us = val;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
        i_cfg_data  = BASE_W'($urandom_range(16'hFFFF));
    endtask

    function automatic t_cmd_row dir_row(input logic [OP_W-1:0] op, input int x, input int y,
                                         input int color, input bit typed = 0,
                                         input int t_row = 0, input int t_hold = 0,
                                         input int t_rgb = 0);
        t_cmd_row r;
        r.op     = op;
        r.x      = x[PIX_X_W-1:0];
        r.y      = y[PIX_Y_W-1:0];
        r.color  = color[COLOR_W-1:0];
        r.typed  = typed;
        r.t_row  = t_row[ROW_ADDR_W-1:0];
        r.t_hold = t_hold[HOLD_W-1:0];
        r.t_rgb  = t_rgb[5:0];
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    t_cmd_row directed_rows[$];

    initial begin : stimulus
        t_cmd_row               no_typed;
        logic [BASE_W-1:0]      phase_base [4];
        int unsigned            phase_idle [4];
        int unsigned            counted;
        int unsigned            pick;
        logic [OP_W-1:0]        op;
        logic [PIX_X_W-1:0]     x;
        logic [PIX_Y_W-1:0]     y;
        logic [COLOR_W-1:0]     color;

        // every input known from time zero; reset held low at the start
        i_rst_n       = 1'b0;
        i_start       = 1'b0;
        i_operation   = OP_REFRESH;
        i_pixel_x     = '0;
        i_pixel_y     = '0;
        i_pixel_color = '0;
        i_cfg_valid   = 1'b0;
        i_cfg_data    = '0;
        no_typed      = '0;
        reset_panel_model();
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed table. Base period is still at its reset value of 100.
        // Front buffer is all zero until the first frame end, so the first
        // refresh steps can be written out: row 0, planes 0..3, dark pixels.
        directed_rows.push_back(dir_row(OP_REFRESH, 0, 0, 0, 1, 0, 100, 0));
        directed_rows.push_back(dir_row(OP_REFRESH, 0, 0, 0, 1, 0, 200, 0));
        directed_rows.push_back(dir_row(OP_UNUSED, 31, 15, 16'hFFFF));   // ignored
        directed_rows.push_back(dir_row(OP_WRITE, 0, 0, 16'hFFFF));      // corner, full white
        directed_rows.push_back(dir_row(OP_WRITE, 31, 15, 16'hFFFF));    // opposite corner
        directed_rows.push_back(dir_row(OP_WRITE, 31, 8, 16'h0000));
        directed_rows.push_back(dir_row(OP_WRITE, 0, 8, 16'hFFFF));      // lower half, pair 0
        directed_rows.push_back(dir_row(OP_WRITE, 17, 9, 16'h5555));
        directed_rows.push_back(dir_row(OP_WRITE, 10, 2, 16'hAAAA));
        directed_rows.push_back(dir_row(OP_WRITE, 0, 7, 16'hFFFF));
        directed_rows.push_back(dir_row(OP_SWAP, 0, 0, 0));
        directed_rows.push_back(dir_row(OP_SWAP, 5, 5, 16'h1234));       // repeat stays one swap
        // back buffer writes must not leak onto the panel before the swap
        directed_rows.push_back(dir_row(OP_REFRESH, 0, 0, 0, 1, 0, 400, 0));
        directed_rows.push_back(dir_row(OP_REFRESH, 0, 0, 0, 1, 0, 800, 0));
        directed_rows.push_back(dir_row(OP_REFRESH, 0, 0, 0));
        directed_rows.push_back(dir_row(OP_UNUSED, 0, 0, 0));
        directed_rows.push_back(dir_row(OP_REFRESH, 0, 0, 0));
        directed_rows.push_back(dir_row(OP_WRITE, 31, 0, 16'h8001));
        directed_rows.push_back(dir_row(OP_WRITE, 1, 15, 16'h7FFE));
        directed_rows.push_back(dir_row(OP_REFRESH, 0, 0, 0));

        foreach (directed_rows[i])
            send_cmd(directed_rows[i].op, directed_rows[i].x, directed_rows[i].y,
                     directed_rows[i].color, 0, directed_rows[i]);

        // Random phases: base period extremes and zero, different sender idling.
        phase_base[0] = 16'hFFFF;               phase_idle[0] = 0;
        phase_base[1] = 16'd1;                  phase_idle[1] = 68;
        phase_base[2] = BASE_W'($urandom_range(2, 16'hFFFE)); phase_idle[2] = 8;
        phase_base[3] = 16'd0;                  phase_idle[3] = 0;

        for (int p = 0; p < 4; p++) begin
            program_base(phase_base[p]);
            counted = 0;
            while (counted < PHASE_CMDS) begin
                // occasionally stop and let every owed beat come out
                if ($urandom_range(29) == 0) drain_beats();
                pick = $urandom_range(99);
                if (pick < 50)      op = OP_REFRESH;
                else if (pick < 88) op = OP_WRITE;
                else if (pick < 95) op = OP_SWAP;
                else                op = OP_UNUSED;
                x     = ($urandom_range(7) == 0) ? ($urandom_range(1) ? 5'd31 : 5'd0)
                                                 : PIX_X_W'($urandom_range(31));
                y     = ($urandom_range(7) == 0) ? ($urandom_range(1) ? 4'd15 : 4'd0)
                                                 : PIX_Y_W'($urandom_range(15));
                color = ($urandom_range(7) == 0) ? ($urandom_range(1) ? 16'hFFFF : 16'h0000)
                                                 : COLOR_W'($urandom_range(16'hFFFF));
                send_cmd(op, x, y, color, phase_idle[p], no_typed);
                if (op != OP_UNUSED) counted++;
            end
        end

        // wind down: all beats out, then room for a trailing buffer clear
        drain_beats();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("covered %0d transactions, %0d refresh steps, %0d beats checked",
                 cmds_taken, refresh_steps, beats_checked);
        $display("frame swaps observed %0d, base period at 100/65535/1/random/0, errors %0d",
                 swaps_seen, err_count);
        if (err_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
